### rtl/llh_pkg.sv
// Shared types and constants for the login handshake controller.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package llh_pkg;

    // Field widths of the items, second counters and configuration indexes.
    localparam int unsigned CmdW  = 3;
    localparam int unsigned CodeW = 2;
    localparam int unsigned PktW  = 3;
    localparam int unsigned StW   = 3;
    localparam int unsigned SecW  = 8;
    localparam int unsigned CfgIdxW = 2;

    // Stream payload widths, rounded up to whole bytes.
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 8;

    // Configuration register reset values.
    localparam logic [SecW-1:0] PingIntervalRst = 8'd5;
    localparam logic [SecW-1:0] RxTimeoutRst    = 8'd30;
    localparam logic [SecW-1:0] RetryDelayRst   = 8'd5;
    localparam logic [SecW-1:0] SecMax          = 8'd255;

    // Event codes carried in the slave-side tuser.
    typedef enum logic [CmdW-1:0] {
        CMD_POLL  = 3'd0,
        CMD_TOKEN = 3'd1,
        CMD_ACK   = 3'd2,
        CMD_NAK   = 3'd3,
        CMD_PONG  = 3'd4,
        CMD_CLOSE = 3'd5,
        CMD_VALID = 3'd6
    } cmd_t;

    // Result codes of an ack.
    localparam logic [CodeW-1:0] ACK_AUTH   = 2'd0;
    localparam logic [CodeW-1:0] ACK_CONFIG = 2'd1;
    localparam logic [CodeW-1:0] ACK_CLOSE  = 2'd2;

    // Result codes of a nak that are acted on.
    localparam logic [CodeW-1:0] NAK_HMAC     = 2'd0;
    localparam logic [CodeW-1:0] NAK_CLIENTID = 2'd1;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_PING_INTERVAL = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RX_TIMEOUT    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_RETRY_DELAY   = 2'd2;

    // Link states.
    typedef enum logic [StW-1:0] {
        ST_INIT        = 3'd0,
        ST_LOGIN_SENT  = 3'd1,
        ST_AUTH_SENT   = 3'd2,
        ST_CONFIG_SENT = 3'd3,
        ST_CONNECTED   = 3'd4,
        ST_CLOSED      = 3'd5
    } link_state_t;

    // Packets to send.
    typedef enum logic [PktW-1:0] {
        PKT_NONE   = 3'd0,
        PKT_LOGIN  = 3'd1,
        PKT_AUTH   = 3'd2,
        PKT_CONFIG = 3'd3,
        PKT_PING   = 3'd4,
        PKT_CLOSE  = 3'd5
    } pkt_t;

    // Configuration register bundle.
    typedef struct packed {
        logic [SecW-1:0] ping_interval;
        logic [SecW-1:0] rx_timeout;
        logic [SecW-1:0] retry_delay;
    } cfg_t;

    // Controller state bundle.
    typedef struct packed {
        link_state_t     conn_state;
        logic [SecW-1:0] secs_since_valid;
        logic [SecW-1:0] secs_since_sent;
        logic [SecW-1:0] retry_holdoff;
    } ctx_t;

    // One registered input item.
    typedef struct packed {
        logic [CmdW-1:0]  cmd;
        logic [CodeW-1:0] result_code;
        logic             second_tick;
    } item_t;

    // One result item.
    typedef struct packed {
        logic            ignored;
        logic            running;
        link_state_t     link_state;
        pkt_t            send_packet;
    } result_t;

    // Saturating increment of a second counter.
    function automatic logic [SecW-1:0] sat_inc(input logic [SecW-1:0] v);
        sat_inc = (v == SecMax) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

### rtl/link_login_handshake_fsm_core.sv
// Top level of the client-side login handshake controller.
// Depends on llh_pkg, llh_cfg and llh_step.
`default_nettype none

// Each event item yields exactly one result item. An item is first captured
// in an input register, then the event logic updates the link state and the
// second counters and loads the result register once that register is empty
// or being taken, so m_tvalid rises after the item has passed the input and
// result registers, and one item is taken every cycle while the result side
// keeps up. The combinational state update between them sets that rate.
// Configuration writes take effect on the next clock edge and are meant to be
// issued only while no item is in flight.
module link_login_handshake_fsm_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Event items.
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    input  wire logic [llh_pkg::InDataW-1:0]  s_tdata,  // [1:0] result_code, [2] second_tick
    input  wire logic [llh_pkg::CmdW-1:0]     s_tuser,  // [2:0] cmd
    // Result items.
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    output      logic [llh_pkg::OutDataW-1:0] m_tdata,  // [2:0] send_packet,
                                                        // [5:3] link_state,
                                                        // [6] running, [7] ignored
    // Configuration writes.
    input  wire logic                         cfg_we,
    input  wire logic [llh_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [llh_pkg::SecW-1:0]     cfg_data
);
    import llh_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    logic    out_valid_reg;
    ctx_t    ctx_reg;
    ctx_t    ctx_next;
    result_t res_next;
    logic    advance;
    logic    fire;

    llh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    llh_step u_step (
        .item     (item_reg),
        .ctx      (ctx_reg),
        .cfg      (cfg),
        .ctx_next (ctx_next),
        .result   (res_next)
    );

    // Pipeline flow: the result register frees up when empty or taken.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.cmd         <= s_tuser;
            item_reg.result_code <= s_tdata[CodeW-1:0];
            item_reg.second_tick <= s_tdata[CodeW];
        end
    end

    // Link state and second counters, updated once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.conn_state       <= ST_INIT;
            ctx_reg.secs_since_valid <= '0;
            ctx_reg.secs_since_sent  <= '0;
            ctx_reg.retry_holdoff    <= '0;
        end
        else if (fire)
        begin
            ctx_reg <= ctx_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    // Checks on the controller's own logic.
    a_running_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6] == (m_tdata[5:3] != ST_CLOSED)))
        else $error("running flag disagrees with link state");

    a_ignored_sends_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[7]) |-> (m_tdata[2:0] == PKT_NONE))
        else $error("ignored event produced a packet");

    a_closed_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (ctx_reg.conn_state == ST_CLOSED) |=> (ctx_reg.conn_state == ST_CLOSED))
        else $error("link left the closed state");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

### rtl/llh_cfg.sv
// Configuration registers of the login handshake controller.
// Depends on llh_pkg for widths, register indexes and reset values.
`default_nettype none

module llh_cfg (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [llh_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [llh_pkg::SecW-1:0]    cfg_data,
    output llh_pkg::cfg_t               cfg
);
    import llh_pkg::*;

    cfg_t cfg_reg;

    // Decode the register index; index 3 is not a register and is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ping_interval <= PingIntervalRst;
            cfg_reg.rx_timeout    <= RxTimeoutRst;
            cfg_reg.retry_delay   <= RetryDelayRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PING_INTERVAL: cfg_reg.ping_interval <= cfg_data;
                CFG_RX_TIMEOUT:    cfg_reg.rx_timeout    <= cfg_data;
                CFG_RETRY_DELAY:   cfg_reg.retry_delay   <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/llh_step.sv
// Next-state and result logic for one event of the login handshake.
// Depends on llh_pkg; purely combinational, fed from the input register.
`default_nettype none

module llh_step (
    input  wire llh_pkg::item_t   item,
    input  wire llh_pkg::ctx_t    ctx,
    input  wire llh_pkg::cfg_t    cfg,
    output      llh_pkg::ctx_t    ctx_next,
    output      llh_pkg::result_t result
);
    import llh_pkg::*;

    logic       ign;
    pkt_t       send;
    ctx_t       nxt;
    logic [SecW-1:0] valid_t;
    logic [SecW-1:0] sent_t;
    logic [SecW-1:0] hold_t;

    // Counter values after a poll's one-second tick.
    always_comb
    begin
        valid_t = ctx.secs_since_valid;
        sent_t  = ctx.secs_since_sent;
        hold_t  = ctx.retry_holdoff;
        if (item.second_tick)
        begin
            valid_t = sat_inc(ctx.secs_since_valid);
            sent_t  = sat_inc(ctx.secs_since_sent);
            if (ctx.retry_holdoff != '0)
            begin
                hold_t = ctx.retry_holdoff - 1'b1;
            end
        end
    end

    // Event decode and state transitions.
    always_comb
    begin
        nxt  = ctx;
        send = PKT_NONE;
        ign  = 1'b0;
        unique case (cmd_t'(item.cmd))
            CMD_POLL:
            begin
                nxt.secs_since_valid = valid_t;
                nxt.secs_since_sent  = sent_t;
                nxt.retry_holdoff    = hold_t;
                unique case (ctx.conn_state)
                    ST_INIT:
                    begin
                        if (hold_t == '0)
                        begin
                            nxt.secs_since_valid = '0;
                            nxt.secs_since_sent  = '0;
                            nxt.conn_state       = ST_LOGIN_SENT;
                            send                 = PKT_LOGIN;
                        end
                    end
                    ST_CONNECTED:
                    begin
                        if (sent_t > cfg.ping_interval)
                        begin
                            nxt.secs_since_sent = '0;
                            send                = PKT_PING;
                        end
                    end
                    ST_CLOSED:
                    begin
                        nxt.conn_state = ST_CLOSED;
                    end
                    default:
                    begin
                        // Handshake states time out back to init.
                        if (valid_t > cfg.rx_timeout)
                        begin
                            nxt.conn_state = ST_INIT;
                        end
                    end
                endcase
            end
            CMD_TOKEN:
            begin
                if (ctx.conn_state == ST_LOGIN_SENT)
                begin
                    nxt.secs_since_valid = '0;
                    nxt.secs_since_sent  = '0;
                    nxt.conn_state       = ST_AUTH_SENT;
                    send                 = PKT_AUTH;
                end
                else
                begin
                    ign = 1'b1;
                end
            end
            CMD_ACK:
            begin
                if (ctx.conn_state == ST_AUTH_SENT && item.result_code == ACK_AUTH)
                begin
                    nxt.secs_since_valid = '0;
                    nxt.secs_since_sent  = '0;
                    nxt.conn_state       = ST_CONFIG_SENT;
                    send                 = PKT_CONFIG;
                end
                else if (ctx.conn_state == ST_CONFIG_SENT &&
                         item.result_code == ACK_CONFIG)
                begin
                    nxt.secs_since_valid = '0;
                    nxt.conn_state       = ST_CONNECTED;
                end
                else if (ctx.conn_state == ST_CONNECTED &&
                         item.result_code == ACK_CLOSE)
                begin
                    nxt.secs_since_valid = '0;
                    nxt.conn_state       = ST_CLOSED;
                end
                else
                begin
                    ign = 1'b1;
                end
            end
            CMD_NAK:
            begin
                if (ctx.conn_state == ST_AUTH_SENT &&
                    (item.result_code == NAK_HMAC || item.result_code == NAK_CLIENTID))
                begin
                    nxt.retry_holdoff = cfg.retry_delay;
                    nxt.conn_state    = ST_INIT;
                end
                else
                begin
                    ign = 1'b1;
                end
            end
            CMD_PONG:
            begin
                if (ctx.conn_state == ST_CONNECTED)
                begin
                    nxt.secs_since_valid = '0;
                end
                else
                begin
                    ign = 1'b1;
                end
            end
            CMD_CLOSE:
            begin
                nxt.secs_since_sent = '0;
                send                = PKT_CLOSE;
            end
            CMD_VALID:
            begin
                nxt.secs_since_valid = '0;
            end
            default:
            begin
                ign = 1'b1;
            end
        endcase
    end

    assign ctx_next           = nxt;
    assign result.send_packet = send;
    assign result.link_state  = nxt.conn_state;
    assign result.running     = (nxt.conn_state != ST_CLOSED);
    assign result.ignored     = ign;

endmodule

`default_nettype wire
